FILE: hdl/rectangle_fill_plane_mask_unit_assert.svh
// Assertion macros shared by the rectangle fill unit RTL.
`ifndef RECTANGLE_FILL_PLANE_MASK_UNIT_ASSERT_SVH
`define RECTANGLE_FILL_PLANE_MASK_UNIT_ASSERT_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define RFPM_ASSERT_SAME(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rfpm assertion failed");

// Checks that the consequent holds in the cycle after the antecedent.
`define RFPM_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rfpm assertion failed");

`endif

FILE: hdl/rfpm_pkg.sv
// Package with types and constants of the rectangle fill unit.
`timescale 1ns / 1ps
`default_nettype none

package rfpm_pkg;

    localparam int MAX_WIDTH  = 256;
    localparam int MAX_HEIGHT = 256;
    localparam int MEM_DEPTH  = MAX_WIDTH * MAX_HEIGHT;
    localparam int ADDR_W     = $clog2(MEM_DEPTH);

    localparam int CFG_W   = 9;
    localparam int RGB_W   = 24;
    localparam int COUNT_W = 17;
    localparam int CLIP_W  = 18;
    localparam int PADDR_W = 3;

    localparam logic [CFG_W-1:0]   FRAME_RESET  = 9'd256;
    localparam logic [31:0]        ALPHA_OPAQUE = 32'hff000000;
    localparam logic [COUNT_W-1:0] COUNT_MAX    = 17'h1ffff;

    localparam logic REG_FRAME_WIDTH  = 1'b0;
    localparam logic REG_FRAME_HEIGHT = 1'b1;

    localparam logic MODE_FILL = 1'b0;
    localparam logic MODE_READ = 1'b1;

    typedef struct packed {
        logic               mode;
        logic signed [15:0] rect_x;
        logic signed [15:0] rect_y;
        logic [15:0]        rect_width;
        logic [15:0]        rect_height;
        logic [RGB_W-1:0]   fill_color;
        logic [RGB_W-1:0]   write_mask;
        logic [7:0]         pixel_x;
        logic [7:0]         pixel_y;
    } rfpm_cmd_t;

    typedef struct packed {
        logic [31:0]        pixel_value;
        logic [COUNT_W-1:0] pixels_written;
        logic               out_of_range;
    } rfpm_rsp_t;

    typedef struct packed {
        logic [CFG_W-1:0] width;
        logic [CFG_W-1:0] height;
    } rfpm_frame_t;

    typedef struct packed {
        logic             empty;
        logic [CFG_W-1:0] xa;
        logic [CFG_W-1:0] xb;
        logic [CFG_W-1:0] ya;
        logic [CFG_W-1:0] yb;
    } rfpm_region_t;

endpackage

`default_nettype wire

FILE: hdl/rfpm_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
`timescale 1ns / 1ps
`default_nettype none

module rfpm_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 65536
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

FILE: hdl/rfpm_cfg.sv
// Frame size registers behind the APB-style configuration port.
`timescale 1ns / 1ps
`default_nettype none

module rfpm_cfg (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [rfpm_pkg::PADDR_W-1:0] paddr,
    input  wire logic [31:0]                 pwdata,
    output logic      [31:0]                 prdata,
    output logic                             pready,
    output rfpm_pkg::rfpm_frame_t            frame
);

    logic [rfpm_pkg::CFG_W-1:0] width_reg;
    logic [rfpm_pkg::CFG_W-1:0] width_next;
    logic [rfpm_pkg::CFG_W-1:0] height_reg;
    logic [rfpm_pkg::CFG_W-1:0] height_next;
    logic                       wr_en;
    logic                       reg_sel;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_sel = paddr[2];

    always_comb
    begin
        width_next  = width_reg;
        height_next = height_reg;
        if (wr_en)
        begin
            case (reg_sel)
                rfpm_pkg::REG_FRAME_WIDTH:  width_next  = pwdata[rfpm_pkg::CFG_W-1:0];
                rfpm_pkg::REG_FRAME_HEIGHT: height_next = pwdata[rfpm_pkg::CFG_W-1:0];
                default:                    width_next  = width_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= rfpm_pkg::FRAME_RESET;
            height_reg <= rfpm_pkg::FRAME_RESET;
        end
        else
        begin
            width_reg  <= width_next;
            height_reg <= height_next;
        end
    end

    always_comb
    begin
        case (reg_sel)
            rfpm_pkg::REG_FRAME_WIDTH:  prdata = {23'd0, width_reg};
            rfpm_pkg::REG_FRAME_HEIGHT: prdata = {23'd0, height_reg};
            default:                    prdata = 32'd0;
        endcase
    end

    // Sizes above the store dimensions are limited to them.
    assign frame.width  = (32'(width_reg) > rfpm_pkg::MAX_WIDTH)
                          ? rfpm_pkg::CFG_W'(rfpm_pkg::MAX_WIDTH) : width_reg;
    assign frame.height = (32'(height_reg) > rfpm_pkg::MAX_HEIGHT)
                          ? rfpm_pkg::CFG_W'(rfpm_pkg::MAX_HEIGHT) : height_reg;

endmodule

`default_nettype wire

FILE: hdl/rfpm_clip.sv
// Clips a fill rectangle against the frame and registers the resulting region.
`timescale 1ns / 1ps
`default_nettype none

module rfpm_clip (
    input  wire logic                  clk,
    input  wire logic                  load,
    input  wire rfpm_pkg::rfpm_cmd_t   cmd,
    input  wire rfpm_pkg::rfpm_frame_t frame,
    output rfpm_pkg::rfpm_region_t     region
);

    logic signed [rfpm_pkg::CLIP_W-1:0] x0;
    logic signed [rfpm_pkg::CLIP_W-1:0] x1;
    logic signed [rfpm_pkg::CLIP_W-1:0] x1c;
    logic signed [rfpm_pkg::CLIP_W-1:0] xlim;
    logic signed [rfpm_pkg::CLIP_W-1:0] y0;
    logic signed [rfpm_pkg::CLIP_W-1:0] y1;
    logic signed [rfpm_pkg::CLIP_W-1:0] y1c;
    logic signed [rfpm_pkg::CLIP_W-1:0] ylim;
    rfpm_pkg::rfpm_region_t             region_reg;
    rfpm_pkg::rfpm_region_t             region_next;

    always_comb
    begin
        xlim = $signed({9'd0, frame.width});
        ylim = $signed({9'd0, frame.height});
        x0   = cmd.rect_x[15] ? '0 : rfpm_pkg::CLIP_W'(cmd.rect_x);
        y0   = cmd.rect_y[15] ? '0 : rfpm_pkg::CLIP_W'(cmd.rect_y);
        x1   = rfpm_pkg::CLIP_W'(cmd.rect_x) + $signed({2'b00, cmd.rect_width});
        y1   = rfpm_pkg::CLIP_W'(cmd.rect_y) + $signed({2'b00, cmd.rect_height});
        x1c  = (x1 > xlim) ? xlim : x1;
        y1c  = (y1 > ylim) ? ylim : y1;

        region_next.empty = !((x1c > x0) && (y1c > y0));
        region_next.xa    = x0[rfpm_pkg::CFG_W-1:0];
        region_next.xb    = x1c[rfpm_pkg::CFG_W-1:0];
        region_next.ya    = y0[rfpm_pkg::CFG_W-1:0];
        region_next.yb    = y1c[rfpm_pkg::CFG_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            region_reg <= region_next;
        end
    end

    assign region = region_reg;

endmodule

`default_nettype wire

FILE: hdl/rectangle_fill_plane_mask_unit.sv
// A read goes from the idle state to the result state, which loads the registered store output.
// A fill goes through the clip, fill and drain states before the result state.
// A fill that clips to nothing skips the fill and drain states; no new item is taken until the result is loaded.
// The frame store RAM does one read and one write per cycle, so a fill moves one pixel a cycle.
// After reset a clearing pass writes zero to all 65536 store entries, one per cycle.
// No item is accepted during that pass; configuration writes are taken throughout.
`timescale 1ns / 1ps
`default_nettype none

`include "rectangle_fill_plane_mask_unit_assert.svh"

module rectangle_fill_plane_mask_unit (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         cmd_valid,
    output logic                              cmd_stall,
    input  wire rfpm_pkg::rfpm_cmd_t          cmd,
    output logic                              rsp_valid,
    input  wire logic                         rsp_stall,
    output rfpm_pkg::rfpm_rsp_t               rsp,
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [rfpm_pkg::PADDR_W-1:0] paddr,
    input  wire logic [31:0]                  pwdata,
    output logic      [31:0]                  prdata,
    output logic                              pready
);

    typedef enum logic [5:0] {
        ST_CLEAR  = 6'b000001,
        ST_IDLE   = 6'b000010,
        ST_CLIP   = 6'b000100,
        ST_FILL   = 6'b001000,
        ST_DRAIN  = 6'b010000,
        ST_RESULT = 6'b100000
    } rfpm_state_t;

    rfpm_state_t                   state_reg;
    rfpm_state_t                   state_next;
    logic [rfpm_pkg::ADDR_W-1:0]   clr_reg;
    logic [rfpm_pkg::ADDR_W-1:0]   clr_next;
    logic                          wr_pending_reg;
    logic                          wr_pending_next;
    logic [rfpm_pkg::ADDR_W-1:0]   wr_addr_reg;
    logic [rfpm_pkg::ADDR_W-1:0]   wr_addr_next;
    logic [rfpm_pkg::ADDR_W-1:0]   row_base_reg;
    logic [rfpm_pkg::ADDR_W-1:0]   row_base_next;
    logic [rfpm_pkg::CFG_W-1:0]    x_reg;
    logic [rfpm_pkg::CFG_W-1:0]    x_next;
    logic [rfpm_pkg::CFG_W-1:0]    y_reg;
    logic [rfpm_pkg::CFG_W-1:0]    y_next;
    logic [rfpm_pkg::COUNT_W-1:0]  count_reg;
    logic [rfpm_pkg::COUNT_W-1:0]  count_next;
    logic                          mode_reg;
    logic                          mode_next;
    logic                          oor_reg;
    logic                          oor_next;
    logic [rfpm_pkg::RGB_W-1:0]    color_reg;
    logic [rfpm_pkg::RGB_W-1:0]    color_next;
    logic [rfpm_pkg::RGB_W-1:0]    mask_reg;
    logic [rfpm_pkg::RGB_W-1:0]    mask_next;
    logic                          out_valid_reg;
    logic                          out_valid_next;
    rfpm_pkg::rfpm_rsp_t           out_data_reg;
    rfpm_pkg::rfpm_rsp_t           out_data_next;

    rfpm_pkg::rfpm_frame_t         frame;
    rfpm_pkg::rfpm_region_t        region;
    logic                          accept;
    logic                          out_free;
    logic                          read_oor;
    logic                          ram_we;
    logic [rfpm_pkg::ADDR_W-1:0]   ram_waddr;
    logic [rfpm_pkg::RGB_W-1:0]    ram_wdata;
    logic                          ram_re;
    logic [rfpm_pkg::ADDR_W-1:0]   ram_raddr;
    logic [rfpm_pkg::RGB_W-1:0]    ram_rdata;
    logic [rfpm_pkg::ADDR_W-1:0]   read_addr;
    logic [rfpm_pkg::ADDR_W-1:0]   fill_addr;

    rfpm_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .frame   (frame)
    );

    rfpm_clip u_clip (
        .clk    (clk),
        .load   (accept),
        .cmd    (cmd),
        .frame  (frame),
        .region (region)
    );

    rfpm_ram #(
        .WIDTH (rfpm_pkg::RGB_W),
        .DEPTH (rfpm_pkg::MEM_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign cmd_stall = (state_reg != ST_IDLE);
    assign accept    = cmd_valid && !cmd_stall;
    assign out_free  = !out_valid_reg || !rsp_stall;
    assign rsp_valid = out_valid_reg;
    assign rsp       = out_data_reg;

    assign read_oor  = ({1'b0, cmd.pixel_x} >= frame.width)
                       || ({1'b0, cmd.pixel_y} >= frame.height);
    assign read_addr = rfpm_pkg::ADDR_W'(32'(cmd.pixel_y) * rfpm_pkg::MAX_WIDTH
                                         + 32'(cmd.pixel_x));
    assign fill_addr = row_base_reg + rfpm_pkg::ADDR_W'(x_reg);

    // The write of a pixel lands in the cycle after its read; the next read is always
    // another pixel, and the drain state lets the last write land before any new read.
    always_comb
    begin
        if (state_reg == ST_CLEAR)
        begin
            ram_we    = 1'b1;
            ram_waddr = clr_reg;
            ram_wdata = '0;
        end
        else
        begin
            ram_we    = wr_pending_reg;
            ram_waddr = wr_addr_reg;
            ram_wdata = (color_reg & mask_reg) | (ram_rdata & ~mask_reg);
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        clr_next        = clr_reg;
        wr_pending_next = 1'b0;
        wr_addr_next    = wr_addr_reg;
        row_base_next   = row_base_reg;
        x_next          = x_reg;
        y_next          = y_reg;
        count_next      = count_reg;
        mode_next       = mode_reg;
        oor_next        = oor_reg;
        color_next      = color_reg;
        mask_next       = mask_reg;
        out_valid_next  = out_valid_reg && rsp_stall;
        out_data_next   = out_data_reg;
        ram_re          = 1'b0;
        ram_raddr       = read_addr;

        case (state_reg)
            ST_CLEAR:
            begin
                clr_next = clr_reg + 1'b1;
                if (clr_reg == rfpm_pkg::ADDR_W'(rfpm_pkg::MEM_DEPTH - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    mode_next  = cmd.mode;
                    oor_next   = read_oor;
                    color_next = cmd.fill_color;
                    mask_next  = cmd.write_mask;
                    count_next = '0;
                    if (cmd.mode == rfpm_pkg::MODE_READ)
                    begin
                        ram_re     = !read_oor;
                        state_next = ST_RESULT;
                    end
                    else
                    begin
                        state_next = ST_CLIP;
                    end
                end
            end
            ST_CLIP:
            begin
                x_next        = region.xa;
                y_next        = region.ya;
                row_base_next = rfpm_pkg::ADDR_W'(32'(region.ya) * rfpm_pkg::MAX_WIDTH);
                state_next    = region.empty ? ST_RESULT : ST_FILL;
            end
            ST_FILL:
            begin
                ram_re          = 1'b1;
                ram_raddr       = fill_addr;
                wr_pending_next = 1'b1;
                wr_addr_next    = fill_addr;
                count_next      = (count_reg == rfpm_pkg::COUNT_MAX)
                                  ? count_reg : count_reg + 1'b1;
                x_next          = x_reg + 1'b1;
                if ((x_reg + 1'b1) == region.xb)
                begin
                    x_next        = region.xa;
                    y_next        = y_reg + 1'b1;
                    row_base_next = row_base_reg
                                    + rfpm_pkg::ADDR_W'(rfpm_pkg::MAX_WIDTH);
                    if ((y_reg + 1'b1) == region.yb)
                    begin
                        state_next = ST_DRAIN;
                    end
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_RESULT;
            end
            ST_RESULT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    if (mode_reg == rfpm_pkg::MODE_READ)
                    begin
                        out_data_next.pixel_value    = oor_reg ? 32'd0
                            : (rfpm_pkg::ALPHA_OPAQUE | {8'd0, ram_rdata});
                        out_data_next.pixels_written = '0;
                        out_data_next.out_of_range   = oor_reg;
                    end
                    else
                    begin
                        out_data_next.pixel_value    = 32'd0;
                        out_data_next.pixels_written = count_reg;
                        out_data_next.out_of_range   = 1'b0;
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            clr_reg        <= '0;
            wr_pending_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            clr_reg        <= clr_next;
            wr_pending_reg <= wr_pending_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        wr_addr_reg  <= wr_addr_next;
        row_base_reg <= row_base_next;
        x_reg        <= x_next;
        y_reg        <= y_next;
        count_reg    <= count_next;
        mode_reg     <= mode_next;
        oor_reg      <= oor_next;
        color_reg    <= color_next;
        mask_reg     <= mask_next;
        out_data_reg <= out_data_next;
    end

    `RFPM_ASSERT_SAME(a_no_rw_collision, ram_we && ram_re, ram_waddr != ram_raddr)
    `RFPM_ASSERT_SAME(a_fill_in_region, state_reg == ST_FILL,
                      (x_reg < region.xb) && (y_reg < region.yb))
    `RFPM_ASSERT_NEXT(a_result_loaded, (state_reg == ST_RESULT) && out_free,
                      rsp_valid && (state_reg == ST_IDLE))

endmodule

`default_nettype wire
